/* hw/rtl/bfsh_pkg.sv */
// bfsh_pkg: shared types, constants and seed table of the seven-hash bloom filter
// used by every module under hw/rtl; no dependencies
`default_nettype none

package bfsh_pkg;

    localparam int MAX_FILTER_BITS_DEF = 65536;
    localparam int HASH_COUNT_DEF      = 7;

    localparam int SEED_SLOTS = 7;
    localparam int SEED_W     = 6;
    localparam int HASH_W     = 16;
    localparam int BYTE_W     = 8;
    // widest running value: 65535 * 37 + 255 fits in 22 bits
    localparam int PROD_W     = 22;
    localparam int ROW_BITS   = 32;
    localparam int BIT_SEL_W  = 5;

    localparam logic [HASH_W-1:0] FILTER_BITS_RST = 16'hFFFF;

    localparam logic [SEED_W-1:0] SEEDS [SEED_SLOTS] =
        '{6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd31, 6'd37};

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DIVH,
        S_IDX,
        S_DIVI,
        S_RD,
        S_CHK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic hash_from_tmp;
        logic hash_from_rem;
        logic div_hash;
        logic div_idx;
        logic idx_from_hash;
        logic idx_from_rem;
        logic mem_rd;
        logic mem_set;
        logic ans_upd;
        logic hash_clr;
        logic k_clr;
        logic k_inc;
        logic clr_wr;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic gt_mod;
        logic idx_big;
        logic div_done;
        logic k_last;
        logic clr_last;
        logic last_item;
        logic cmd_check;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/bfsh_divider.sv */
// bfsh_divider: bit-serial restoring remainder unit, one quotient bit per cycle
// depends on bfsh_pkg for operand widths
`default_nettype none

module bfsh_divider (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [bfsh_pkg::PROD_W-1:0]    dividend,
    input  wire logic [bfsh_pkg::HASH_W-1:0]    divisor,
    output logic                                done,
    output logic [bfsh_pkg::HASH_W-1:0]         remainder
);

    localparam int DVD_W = bfsh_pkg::PROD_W;
    localparam int DVS_W = bfsh_pkg::HASH_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(DVD_W - 1);
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[DVS_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/bfsh_datapath.sv */
// bfsh_datapath: running hashes, seed multiply, bit store rows, answer and modulus register
// depends on bfsh_pkg and bfsh_divider
`default_nettype none

module bfsh_datapath #(
    parameter int MAX_FILTER_BITS = bfsh_pkg::MAX_FILTER_BITS_DEF,
    parameter int HASH_COUNT      = bfsh_pkg::HASH_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfsh_pkg::HASH_W-1:0]   cfg_wr_data,
    input  wire logic                          in_cmd,
    input  wire logic [bfsh_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                          in_last,
    input  wire bfsh_pkg::ctrl_cmd_t           cmd,
    output bfsh_pkg::dp_status_t               status,
    output logic                               out_answer
);

    localparam int HW     = bfsh_pkg::HASH_W;
    localparam int PW     = bfsh_pkg::PROD_W;
    localparam int RB     = bfsh_pkg::ROW_BITS;
    localparam int BSW    = bfsh_pkg::BIT_SEL_W;
    localparam int ROWS   = (MAX_FILTER_BITS + RB - 1) / RB;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int K_W    = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
    localparam bit IDX_WRAP = (MAX_FILTER_BITS < 65536);
    localparam logic [HW-1:0] MAX_DIV = IDX_WRAP ? HW'(MAX_FILTER_BITS) : '1;
    // reciprocal of the store size, exact quotient for every 16-bit hash
    localparam int RCP_W  = 27;
    localparam int QP_W   = HW + RCP_W;
    localparam int QW     = QP_W - 32;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << 32) + 64'(MAX_DIV) - 64'd1) / 64'(MAX_DIV));

    logic [HW-1:0]                    filter_bits_reg;
    logic [HW-1:0]                    hash_reg [HASH_COUNT];
    logic [K_W-1:0]                   k_reg;
    logic                             cmd_reg;
    logic [bfsh_pkg::BYTE_W-1:0]      byte_reg;
    logic                             last_reg;
    logic [PW-1:0]                    tmp_reg;
    logic [HW-1:0]                    idx_reg;
    logic [QW-1:0]                    q_reg;
    logic                             ans_reg;
    logic                             out_ans_reg;
    logic [ROW_W-1:0]                 clr_row_reg;
    logic [RB-1:0]                    rd_data_reg;
    logic [RB-1:0]                    mem [ROWS];

    logic [HW-1:0]                    mod_val;
    logic [HW-1:0]                    hash_cur;
    logic [bfsh_pkg::SEED_W-1:0]      seed_cur;
    logic [PW-1:0]                    prod;
    logic [QP_W-1:0]                  q_prod;
    logic [HW-1:0]                    idx_rem;
    logic                             div_start;
    logic [PW-1:0]                    div_dividend;
    logic [HW-1:0]                    div_divisor;
    logic                             div_done;
    logic [HW-1:0]                    div_rem;
    logic [ROW_W-1:0]                 row_addr;
    logic                             mem_we;
    logic [ROW_W-1:0]                 mem_waddr;
    logic [RB-1:0]                    mem_wdata;
    logic                             bit_hit;

    always_comb begin
        mod_val      = (filter_bits_reg == '0) ? HW'(1) : filter_bits_reg;
        hash_cur     = hash_reg[k_reg];
        seed_cur     = bfsh_pkg::SEEDS[3'(k_reg)];
        prod         = PW'(hash_cur) * PW'(seed_cur) + PW'(byte_reg);
        q_prod       = QP_W'(hash_cur) * QP_W'(RECIP);
        idx_rem      = hash_cur - HW'(q_reg) * MAX_DIV;
        div_start    = cmd.div_hash;
        div_dividend = tmp_reg;
        div_divisor  = mod_val;
        row_addr     = ROW_W'(idx_reg >> BSW);
        bit_hit      = rd_data_reg[idx_reg[BSW-1:0]];
        mem_we       = cmd.clr_wr | cmd.mem_set;
        mem_waddr    = cmd.clr_wr ? clr_row_reg : row_addr;
        mem_wdata    = cmd.clr_wr ? '0 : (rd_data_reg | (RB'(1) << idx_reg[BSW-1:0]));
    end

    bfsh_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_bits_reg <= bfsh_pkg::FILTER_BITS_RST;
            k_reg           <= '0;
            clr_row_reg     <= '0;
            for (int i = 0; i < HASH_COUNT; i++) begin
                hash_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                filter_bits_reg <= cfg_wr_data;
            end
            if (cmd.clr_wr) begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
            if (cmd.k_clr) begin
                k_reg <= '0;
            end else if (cmd.k_inc) begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.hash_clr) begin
                for (int i = 0; i < HASH_COUNT; i++) begin
                    hash_reg[i] <= '0;
                end
            end else if (cmd.hash_from_tmp) begin
                hash_reg[k_reg] <= tmp_reg[HW-1:0];
            end else if (cmd.hash_from_rem) begin
                hash_reg[k_reg] <= div_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg  <= in_cmd;
            byte_reg <= in_byte;
            last_reg <= in_last;
            ans_reg  <= 1'b1;
        end else if (cmd.ans_upd) begin
            ans_reg <= ans_reg & bit_hit;
        end
        if (cmd.mul) begin
            tmp_reg <= prod;
        end
        if (cmd.div_idx) begin
            q_reg <= q_prod[QP_W-1:32];
        end
        if (cmd.idx_from_hash) begin
            idx_reg <= hash_cur;
        end else if (cmd.idx_from_rem) begin
            idx_reg <= idx_rem;
        end
        if (cmd.out_load) begin
            out_ans_reg <= ans_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[row_addr];
        end
    end

    always_comb begin
        status.gt_mod    = (tmp_reg > PW'(mod_val));
        status.idx_big   = IDX_WRAP && (hash_cur >= MAX_DIV);
        status.div_done  = div_done;
        status.k_last    = (k_reg == K_W'(HASH_COUNT - 1));
        status.clr_last  = (clr_row_reg == ROW_W'(ROWS - 1));
        status.last_item = last_reg;
        status.cmd_check = (cmd_reg == bfsh_pkg::CMD_CHECK);
    end

    assign out_answer = out_ans_reg;

endmodule

`default_nettype wire

/* hw/rtl/bfsh_ctrl.sv */
// bfsh_ctrl: sequencer for clearing pass, per-byte hash updates and key-end bit accesses
// depends on bfsh_pkg for state and command types
`default_nettype none

module bfsh_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire bfsh_pkg::dp_status_t  status,
    output bfsh_pkg::ctrl_cmd_t        cmd
);

    bfsh_pkg::state_t state_reg;
    bfsh_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bfsh_pkg::S_CLR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            bfsh_pkg::S_CLR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = bfsh_pkg::S_IDLE;
                end
            end
            bfsh_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.k_clr   = 1'b1;
                    state_next  = bfsh_pkg::S_MUL;
                end
            end
            bfsh_pkg::S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = bfsh_pkg::S_CMP;
            end
            bfsh_pkg::S_CMP, bfsh_pkg::S_DIVH: begin
                if (state_reg == bfsh_pkg::S_CMP && status.gt_mod) begin
                    cmd.div_hash = 1'b1;
                    state_next   = bfsh_pkg::S_DIVH;
                end else if (state_reg == bfsh_pkg::S_CMP || status.div_done) begin
                    cmd.hash_from_tmp = (state_reg == bfsh_pkg::S_CMP);
                    cmd.hash_from_rem = (state_reg == bfsh_pkg::S_DIVH);
                    if (!status.k_last) begin
                        cmd.k_inc  = 1'b1;
                        state_next = bfsh_pkg::S_MUL;
                    end else if (status.last_item) begin
                        cmd.k_clr  = 1'b1;
                        state_next = bfsh_pkg::S_IDX;
                    end else begin
                        state_next = bfsh_pkg::S_IDLE;
                    end
                end
            end
            bfsh_pkg::S_IDX: begin
                if (status.idx_big) begin
                    cmd.div_idx = 1'b1;
                    state_next  = bfsh_pkg::S_DIVI;
                end else begin
                    cmd.idx_from_hash = 1'b1;
                    state_next        = bfsh_pkg::S_RD;
                end
            end
            bfsh_pkg::S_DIVI: begin
                cmd.idx_from_rem = 1'b1;
                state_next       = bfsh_pkg::S_RD;
            end
            bfsh_pkg::S_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = bfsh_pkg::S_CHK;
            end
            bfsh_pkg::S_CHK: begin
                cmd.mem_set = !status.cmd_check;
                cmd.ans_upd = status.cmd_check;
                if (status.k_last) begin
                    state_next = bfsh_pkg::S_FIN;
                end else begin
                    cmd.k_inc  = 1'b1;
                    state_next = bfsh_pkg::S_IDX;
                end
            end
            bfsh_pkg::S_FIN: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    cmd.hash_clr   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bfsh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bfsh_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/bloom_filter_seven_hash.sv */
// bloom_filter_seven_hash: top level of the byte-serial bloom filter with seven seeded hashes
// depends on bfsh_pkg, bfsh_ctrl, bfsh_datapath and bfsh_divider
//
//   channel  | direction | tdata            | tuser      | tlast
//   s_       | in        | [7:0] key_byte   | [0] cmd    | last
//   m_       | out       | [0] answer       | -          | -
//   cfg_     | in        | filter_bits via cfg_wr_data, written when cfg_wr_en is high
//
// one item in flight; per byte: an idle state, then per hash a multiply and a compare,
// plus the serial remainder unit when the product exceeds filter_bits
// key end adds per hash an index, a read and a check state (plus a divide state
// when the index wraps a small store) and a final state handing the answer to the output
// register; after reset a clearing pass zeroes all ceil(MAX_FILTER_BITS/32) rows, s_tready low
// a waiting answer stalls only the next key end, not the intake of bytes
`default_nettype none

module bloom_filter_seven_hash #(
    parameter int MAX_FILTER_BITS = bfsh_pkg::MAX_FILTER_BITS_DEF,
    parameter int HASH_COUNT      = bfsh_pkg::HASH_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfsh_pkg::HASH_W-1:0]   cfg_wr_data,   // filter_bits
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,       // [7:0] key_byte
    input  wire logic                          s_tuser,       // [0] cmd
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata        // [0] answer, rest zero
);

    bfsh_pkg::ctrl_cmd_t  cmd;
    bfsh_pkg::dp_status_t status;
    logic                 answer;

    bfsh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bfsh_datapath #(
        .MAX_FILTER_BITS (MAX_FILTER_BITS),
        .HASH_COUNT      (HASH_COUNT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_tuser),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .out_answer  (answer)
    );

    assign m_tdata = {7'b0, answer};

endmodule

`default_nettype wire
